FILE: rtl/cjt_pkg.sv
// ----------------------------------------------------------------------------
// cjt_pkg
// Shared widths, codes, reset values and types of the junction tracker.
// ----------------------------------------------------------------------------
package cjt_pkg;

  // field widths
  localparam int unsigned DistW  = 14;
  localparam int unsigned LevelW = 17;
  localparam int unsigned KindW  = 3;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = LevelW;

  // number of lanes, one per direction
  localparam int unsigned NumLanes = 4;

  // one quotient bit per divider step, bits 16 down to 0
  localparam int unsigned LaneSteps = LevelW;
  localparam int unsigned StepCntW  = $clog2(LaneSteps);

  // Q1.16 one
  localparam logic [LevelW-1:0] OneQ16 = LevelW'(65536);

  // register indexes
  localparam logic [CfgAddrW-1:0] CfgRangeMin = CfgAddrW'(0);
  localparam logic [CfgAddrW-1:0] CfgRangeMax = CfgAddrW'(1);
  localparam logic [CfgAddrW-1:0] CfgEnter    = CfgAddrW'(2);
  localparam logic [CfgAddrW-1:0] CfgExit     = CfgAddrW'(3);
  localparam logic [CfgAddrW-1:0] CfgDeadEnd  = CfgAddrW'(4);

  // register reset values
  localparam logic [DistW-1:0]  RangeMinRst = DistW'(0);
  localparam logic [DistW-1:0]  RangeMaxRst = DistW'(2500);
  localparam logic [LevelW-1:0] EnterRst    = LevelW'(13763);
  localparam logic [LevelW-1:0] ExitRst     = LevelW'(11796);
  localparam logic [LevelW-1:0] DeadEndRst  = LevelW'(0);

  // junction codes
  typedef enum logic [KindW-1:0] {
    K_NONE       = 3'd0,
    K_ALL        = 3'd1,
    K_RIGHT_T    = 3'd2,
    K_LEFT_T     = 3'd3,
    K_TOP_T      = 3'd4,
    K_DEAD       = 3'd5,
    K_LEFT_TURN  = 3'd6,
    K_RIGHT_TURN = 3'd7
  } kind_t;

  // sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  // levels handed to the merging stage
  typedef struct packed {
    logic [LevelW-1:0] enter_level;
    logic [LevelW-1:0] exit_level;
    logic [LevelW-1:0] dead_end_level;
  } levels_t;

  // lane control and status
  typedef struct packed {
    logic start;
  } lane_ctrl_t;

  typedef struct packed {
    logic              done;
    logic [LevelW-1:0] level;
  } lane_stat_t;

endpackage

FILE: rtl/cjt_if.sv
// ----------------------------------------------------------------------------
// cjt_if
// Valid/ready channels for scan items and result items.
// ----------------------------------------------------------------------------
interface cjt_in_if;
  logic                     valid;
  logic                     ready;
  logic [cjt_pkg::DistW-1:0] dist_left;
  logic [cjt_pkg::DistW-1:0] dist_front;
  logic [cjt_pkg::DistW-1:0] dist_right;
  logic [cjt_pkg::DistW-1:0] dist_back;

  modport source (output valid, output dist_left, output dist_front,
                  output dist_right, output dist_back, input ready);
  modport sink   (input valid, input dist_left, input dist_front,
                  input dist_right, input dist_back, output ready);
endinterface

interface cjt_out_if;
  logic                     valid;
  logic                     ready;
  logic [cjt_pkg::KindW-1:0] detected_kind;
  logic [cjt_pkg::KindW-1:0] held_kind;

  modport source (output valid, output detected_kind, output held_kind, input ready);
  modport sink   (input valid, input detected_kind, input held_kind, output ready);
endinterface

FILE: rtl/corridor_junction_tracker.sv
// ----------------------------------------------------------------------------
// corridor_junction_tracker
// Normalizes the four distances of a scan in four divider lanes and
// tracks corridor junctions from the merged levels.
// ----------------------------------------------------------------------------
//  channel | direction | handshake       | payload
//  in_ch   | in        | valid / ready   | dist_left, dist_front, dist_right, dist_back
//  out_ch  | out       | valid / ready   | detected_kind, held_kind
//  cfg_*   | in        | cfg_we          | cfg_addr, cfg_wdata
//
//  a result is valid once the 17 steps of the lane dividers (one quotient bit
//  a cycle) are done and the result is loaded into the output register
//  one item is in the lanes at a time; the next item is taken from the cycle
//  after the load, even while the previous result is still waiting in the
//  output register
//  a stalled output holds the finished lane levels until the register frees
//  synchronous active-low reset; the held junction returns to none
// ----------------------------------------------------------------------------
module corridor_junction_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  cjt_in_if.sink                        in_ch,
  cjt_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [cjt_pkg::CfgAddrW-1:0]  cfg_addr,
  input  logic [cjt_pkg::CfgDataW-1:0]  cfg_wdata
);

  // configuration registers
  logic [cjt_pkg::DistW-1:0] range_min_r, range_max_r;
  cjt_pkg::levels_t          levels_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r             <= cjt_pkg::RangeMinRst;
      range_max_r             <= cjt_pkg::RangeMaxRst;
      levels_r.enter_level    <= cjt_pkg::EnterRst;
      levels_r.exit_level     <= cjt_pkg::ExitRst;
      levels_r.dead_end_level <= cjt_pkg::DeadEndRst;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        cjt_pkg::CfgRangeMin: range_min_r <= cfg_wdata[cjt_pkg::DistW-1:0];
        cjt_pkg::CfgRangeMax: range_max_r <= cfg_wdata[cjt_pkg::DistW-1:0];
        cjt_pkg::CfgEnter:    levels_r.enter_level    <= cfg_wdata;
        cjt_pkg::CfgExit:     levels_r.exit_level     <= cfg_wdata;
        cjt_pkg::CfgDeadEnd:  levels_r.dead_end_level <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  cjt_pkg::state_t     state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                in_acc, load;
  cjt_pkg::lane_ctrl_t lane_ctrl;
  cjt_pkg::lane_stat_t stat [cjt_pkg::NumLanes];
  logic                lanes_done;

  assign in_acc         = in_ch.valid && in_ch.ready;
  assign lane_ctrl.start = in_acc;
  assign lanes_done     = stat[0].done && stat[1].done && stat[2].done && stat[3].done;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    load          = 1'b0;
    in_ch.ready   = 1'b0;
    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      cjt_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = cjt_pkg::ST_DIV;
        end
      end
      cjt_pkg::ST_DIV: begin
        if (lanes_done && (!out_valid_r || out_ch.ready)) begin
          load          = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = cjt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cjt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cjt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // four normalizing lanes
  cjt_lane u_lane_left (
    .clk(clk), .rst_n(rst_n), .ctrl(lane_ctrl), .dist_mm(in_ch.dist_left),
    .range_min(range_min_r), .range_max(range_max_r), .stat(stat[0])
  );
  cjt_lane u_lane_front (
    .clk(clk), .rst_n(rst_n), .ctrl(lane_ctrl), .dist_mm(in_ch.dist_front),
    .range_min(range_min_r), .range_max(range_max_r), .stat(stat[1])
  );
  cjt_lane u_lane_right (
    .clk(clk), .rst_n(rst_n), .ctrl(lane_ctrl), .dist_mm(in_ch.dist_right),
    .range_min(range_min_r), .range_max(range_max_r), .stat(stat[2])
  );
  cjt_lane u_lane_back (
    .clk(clk), .rst_n(rst_n), .ctrl(lane_ctrl), .dist_mm(in_ch.dist_back),
    .range_min(range_min_r), .range_max(range_max_r), .stat(stat[3])
  );

  // merging stage
  cjt_pkg::kind_t detected_r, held_r;

  cjt_merge u_merge (
    .clk(clk), .rst_n(rst_n), .load(load), .levels(levels_r),
    .lvl_left(stat[0].level), .lvl_front(stat[1].level),
    .lvl_right(stat[2].level), .lvl_back(stat[3].level),
    .detected_r(detected_r), .held_r(held_r)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.detected_kind = detected_r;
  assign out_ch.held_kind     = held_r;

  // lanes run in lock-step
  a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    stat[0].done == stat[3].done && stat[1].done == stat[2].done
    && stat[0].done == stat[1].done)
    else $error("lane done flags disagree");

  // a junction newly reported is also the one held
  a_detect_held: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (detected_r == cjt_pkg::K_NONE || detected_r == held_r))
    else $error("detected junction not held");

  // nothing new is reported while a junction was already held
  a_no_detect_while_held: assert property (@(posedge clk) disable iff (!rst_n)
    load && held_r != cjt_pkg::K_NONE |=> detected_r == cjt_pkg::K_NONE)
    else $error("junction reported while one was held");

  // a result is loaded only after the lanes have finished
  a_load_after_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> lanes_done && state_r == cjt_pkg::ST_DIV)
    else $error("result loaded before lanes finished");

endmodule

FILE: rtl/cjt_lane.sv
// ----------------------------------------------------------------------------
// cjt_lane
// One normalizing lane: maps a distance to Q1.16 with a restoring divider
// that produces one quotient bit a cycle.
// ----------------------------------------------------------------------------
module cjt_lane (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cjt_pkg::lane_ctrl_t        ctrl,
  input  logic [cjt_pkg::DistW-1:0]  dist_mm,
  input  logic [cjt_pkg::DistW-1:0]  range_min,
  input  logic [cjt_pkg::DistW-1:0]  range_max,
  output cjt_pkg::lane_stat_t        stat
);

  localparam int unsigned RemW = cjt_pkg::DistW + 1;

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [cjt_pkg::StepCntW-1:0] cnt_r, cnt_nxt;
  logic [RemW-1:0]              rem_r, rem_nxt;
  logic [cjt_pkg::DistW-1:0]    den_r;
  logic [cjt_pkg::LevelW-1:0]   quo_r, quo_nxt;
  logic                         over_r, zero_r;

  logic            below, above, empty;
  logic            ge;
  logic [RemW-1:0] diff;

  // out-of-range and empty-range checks at start
  assign below = dist_mm < range_min;
  assign above = dist_mm > range_max;
  assign empty = range_max <= range_min;

  // divider step
  assign ge   = rem_r >= {1'b0, den_r};
  assign diff = rem_r - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (ctrl.start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      rem_nxt  = {1'b0, dist_mm - range_min};
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = {(ge ? diff[RemW-2:0] : rem_r[RemW-2:0]), 1'b0};
      quo_nxt = {quo_r[cjt_pkg::LevelW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == cjt_pkg::StepCntW'(cjt_pkg::LaneSteps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (ctrl.start) begin
      den_r  <= range_max - range_min;
      over_r <= !below && above;
      zero_r <= below || (!above && empty);
    end
  end

  // result select
  assign stat.done  = done_r;
  assign stat.level = over_r ? cjt_pkg::OneQ16 : (zero_r ? '0 : quo_r);

endmodule

FILE: rtl/cjt_merge.sv
// ----------------------------------------------------------------------------
// cjt_merge
// Merging stage: classifies the four lane levels or applies the release
// rule of the held junction, and holds the junction and the result.
// ----------------------------------------------------------------------------
module cjt_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  cjt_pkg::levels_t            levels,
  input  logic [cjt_pkg::LevelW-1:0]  lvl_left,
  input  logic [cjt_pkg::LevelW-1:0]  lvl_front,
  input  logic [cjt_pkg::LevelW-1:0]  lvl_right,
  input  logic [cjt_pkg::LevelW-1:0]  lvl_back,
  output cjt_pkg::kind_t              detected_r,
  output cjt_pkg::kind_t              held_r
);

  cjt_pkg::kind_t held_nxt, detected_nxt, found;
  logic le, fe, re, be;
  logic lx, fx, rx, bx;
  logic lgx, rgx, bgx;
  logic fd;
  logic release_hit;

  // threshold compares
  assign le  = lvl_left  > levels.enter_level;
  assign fe  = lvl_front > levels.enter_level;
  assign re  = lvl_right > levels.enter_level;
  assign be  = lvl_back  > levels.enter_level;
  assign lx  = lvl_left  < levels.exit_level;
  assign fx  = lvl_front < levels.exit_level;
  assign rx  = lvl_right < levels.exit_level;
  assign bx  = lvl_back  < levels.exit_level;
  assign lgx = lvl_left  > levels.exit_level;
  assign rgx = lvl_right > levels.exit_level;
  assign bgx = lvl_back  > levels.exit_level;
  assign fd  = lvl_front < levels.dead_end_level;

  // classification in priority order
  always_comb begin
    priority if (le && re && fe && be) found = cjt_pkg::K_ALL;
    else if (re && fe && be)           found = cjt_pkg::K_RIGHT_T;
    else if (le && fe && be)           found = cjt_pkg::K_LEFT_T;
    else if (le && re && be)           found = cjt_pkg::K_TOP_T;
    else if (lx && rx && fd)           found = cjt_pkg::K_DEAD;
    else if (lgx && bgx)               found = cjt_pkg::K_LEFT_TURN;
    else if (rgx && bgx)               found = cjt_pkg::K_RIGHT_TURN;
    else                               found = cjt_pkg::K_NONE;
  end

  // release rule of the held junction; a dead end never releases
  always_comb begin
    unique case (held_r)
      cjt_pkg::K_ALL:        release_hit = lx || rx || fx || bx;
      cjt_pkg::K_RIGHT_T:    release_hit = rx || fx || bx || le;
      cjt_pkg::K_LEFT_T:     release_hit = lx || fx || bx || re;
      cjt_pkg::K_TOP_T:      release_hit = lx || rx || bx || fe;
      cjt_pkg::K_LEFT_TURN:  release_hit = re || lx || fx;
      cjt_pkg::K_RIGHT_TURN: release_hit = le || rx || fx;
      default:               release_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (held_r == cjt_pkg::K_NONE) begin
      detected_nxt = found;
      held_nxt     = found;
    end else begin
      detected_nxt = cjt_pkg::K_NONE;
      held_nxt     = release_hit ? cjt_pkg::K_NONE : held_r;
    end
  end

  // held junction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= cjt_pkg::K_NONE;
    end else if (load) begin
      held_r <= held_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      detected_r <= detected_nxt;
    end
  end

endmodule

FILE: verif/cjt_verdict_check.sv
// ----------------------------------------------------------------------------
// cjt_verdict_check
// Watches the scan and result channels of the junction tracker. Keeps its
// own copy of the range and level registers and of the held junction, works
// out the verdict of every accepted scan item and compares each result item,
// field by field, with the oldest verdict still due.
// ----------------------------------------------------------------------------
module cjt_verdict_check
  import cjt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  cjt_in_if                   in_ch,
  cjt_out_if                  out_ch,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output int unsigned         fail_count,
  output int unsigned         due_count,
  output int unsigned         checked_count,
  output logic [7:0]          kinds_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // one verdict per scan
  typedef struct packed {
    kind_t found;
    kind_t held;
  } verdict_t;

  verdict_t verdicts_due[$];

  // mirrored registers and held junction
  logic [DistW-1:0]  span_lo;
  logic [DistW-1:0]  span_hi;
  logic [LevelW-1:0] open_lvl;
  logic [LevelW-1:0] close_lvl;
  logic [LevelW-1:0] dead_lvl;
  kind_t             held_now;

  int unsigned errors = 0;
  int unsigned due = 0;
  int unsigned checked = 0;
  logic [7:0]  seen = '0;

  assign fail_count    = errors;
  assign due_count     = due;
  assign checked_count = checked;
  assign kinds_seen    = seen;

  // distance in mm to Q1.16 openness against the shared range
  function automatic logic [LevelW-1:0] openness(input logic [DistW-1:0] d);
    longint unsigned num;
    longint unsigned den;
    if (d < span_lo) return '0;
    if (d > span_hi) return OneQ16;
    if (span_hi <= span_lo) return '0;
    num = (longint'(d) - longint'(span_lo)) << 16;
    den = longint'(span_hi) - longint'(span_lo);
    return LevelW'(num / den);
  endfunction

  // first matching pattern wins
  function automatic kind_t classify_scan(input logic [LevelW-1:0] l, f, r, b);
    if (l > open_lvl && r > open_lvl && f > open_lvl && b > open_lvl) return K_ALL;
    if (r > open_lvl && f > open_lvl && b > open_lvl) return K_RIGHT_T;
    if (l > open_lvl && f > open_lvl && b > open_lvl) return K_LEFT_T;
    if (l > open_lvl && r > open_lvl && b > open_lvl) return K_TOP_T;
    if (l < close_lvl && r < close_lvl && f < dead_lvl) return K_DEAD;
    if (l > close_lvl && b > close_lvl) return K_LEFT_TURN;
    if (r > close_lvl && b > close_lvl) return K_RIGHT_TURN;
    return K_NONE;
  endfunction

  // release rule of the held junction; a dead end never lets go
  function automatic bit release_due(input kind_t kind, input logic [LevelW-1:0] l, f, r, b);
    case (kind)
      K_ALL:        return l < close_lvl || r < close_lvl || f < close_lvl || b < close_lvl;
      K_RIGHT_T:    return r < close_lvl || f < close_lvl || b < close_lvl || l > open_lvl;
      K_LEFT_T:     return l < close_lvl || f < close_lvl || b < close_lvl || r > open_lvl;
      K_TOP_T:      return l < close_lvl || r < close_lvl || b < close_lvl || f > open_lvl;
      K_LEFT_TURN:  return r > open_lvl || l < close_lvl || f < close_lvl;
      K_RIGHT_TURN: return l > open_lvl || r < close_lvl || f < close_lvl;
      default:      return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    verdict_t          want;
    logic [LevelW-1:0] lv_l, lv_f, lv_r, lv_b;
    kind_t             found;
    if (!rst_n) begin
      span_lo   = RangeMinRst;
      span_hi   = RangeMaxRst;
      open_lvl  = EnterRst;
      close_lvl = ExitRst;
      dead_lvl  = DeadEndRst;
      held_now  = K_NONE;
      verdicts_due.delete();
      due = 0;
    end else begin
      // result item against the oldest verdict
      if (out_ch.valid && out_ch.ready) begin
        if (verdicts_due.size() == 0) begin
          errors++;
          $display("%0t: result item with nothing due: detected %0d held %0d",
                   $time, out_ch.detected_kind, out_ch.held_kind);
        end else begin
          want = verdicts_due.pop_front();
          due--;
          checked++;
          if (out_ch.detected_kind !== want.found) begin
            errors++;
            $display("%0t: detected_kind expected %0d got %0d",
                     $time, want.found, out_ch.detected_kind);
          end
          if (out_ch.held_kind !== want.held) begin
            errors++;
            $display("%0t: held_kind expected %0d got %0d",
                     $time, want.held, out_ch.held_kind);
          end
        end
      end

      // scan item: normalise, then classify or try to release
      if (in_ch.valid && in_ch.ready) begin
        lv_l  = openness(in_ch.dist_left);
        lv_f  = openness(in_ch.dist_front);
        lv_r  = openness(in_ch.dist_right);
        lv_b  = openness(in_ch.dist_back);
        found = K_NONE;
        if (held_now == K_NONE) begin
          found    = classify_scan(lv_l, lv_f, lv_r, lv_b);
          held_now = found;
        end else if (release_due(held_now, lv_l, lv_f, lv_r, lv_b)) begin
          held_now = K_NONE;
        end
        want.found = found;
        want.held  = held_now;
        seen[found] = 1'b1;
        verdicts_due.push_back(want);
        due++;
      end

      // register writes; unknown indexes are dropped
      if (cfg_we) begin
        case (cfg_addr)
          CfgRangeMin: span_lo   = cfg_wdata[DistW-1:0];
          CfgRangeMax: span_hi   = cfg_wdata[DistW-1:0];
          CfgEnter:    open_lvl  = cfg_wdata;
          CfgExit:     close_lvl = cfg_wdata;
          CfgDeadEnd:  dead_lvl  = cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives scans into the junction tracker under a series of range and level
// settings: a directed pass through each junction kind but the dead end and its
// release, then random scans biased towards the range edges and the level crossings.
// Both channels idle in random bursts; the result side holds off once for a
// long stretch. A dead end is provoked only at the very end, as it is held
// until reset. Checking is done by cjt_verdict_check.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cjt_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 200;

  // an index with no register behind it
  localparam logic [CfgAddrW-1:0] CfgNoReg = CfgAddrW'(7);

  // distances clearly open or closed at the reset range
  localparam logic [DistW-1:0] Far     = DistW'(3000);
  localparam logic [DistW-1:0] Near    = DistW'(100);
  localparam logic [DistW-1:0] DistTop = '1;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;

  cjt_in_if  in_ch ();
  cjt_out_if out_ch ();

  bit idle_on;
  bit hold_req;

  int unsigned       settings;
  logic [DistW-1:0]  cur_min;
  logic [DistW-1:0]  cur_max;
  logic [LevelW-1:0] cur_enter;
  logic [LevelW-1:0] cur_exit;

  int unsigned fails;
  int unsigned due;
  int unsigned checked;
  logic [7:0]  kinds_seen;

  corridor_junction_tracker DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  cjt_verdict_check check_u (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fails),
    .due_count     (due),
    .checked_count (checked),
    .kinds_seen    (kinds_seen)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one register write, one cycle
  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] data);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // stop offering and wait for every result still due
  task automatic drain();
    in_ch.valid = 1'b0;
    while (due != 0) @(negedge clk);
  endtask

  // new register set once the block has gone quiet
  task automatic apply_setting(input logic [DistW-1:0] lo, hi,
                               input logic [LevelW-1:0] en, ex, de);
    drain();
    repeat (25) @(negedge clk);
    write_reg(CfgRangeMin, CfgDataW'(lo));
    write_reg(CfgRangeMax, CfgDataW'(hi));
    write_reg(CfgEnter, en);
    write_reg(CfgExit, ex);
    write_reg(CfgDeadEnd, de);
    cur_min   = lo;
    cur_max   = hi;
    cur_enter = en;
    cur_exit  = ex;
    settings++;
  endtask

  // offer one scan item, with an occasional gap in front of it
  task automatic send_scan(input logic [DistW-1:0] l, f, r, b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.dist_left  = l;
    in_ch.dist_front = f;
    in_ch.dist_right = r;
    in_ch.dist_back  = b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // distance biased to the range edges and the level crossings
  function automatic logic [DistW-1:0] pick_dist();
    int     sel;
    longint lo, hi, lvl, mark;
    lo  = cur_min;
    hi  = cur_max;
    sel = $urandom_range(0, 5);
    case (sel)
      0: mark = $urandom_range(0, 16383);
      1: mark = $urandom_range(0, int'(lo));
      2: mark = $urandom_range(int'(hi), 16383);
      3, 4: begin
        lvl = (sel == 3) ? cur_enter : cur_exit;
        if (lvl > 65536) lvl = 65536;
        mark = (hi > lo) ? lo + ((lvl * (hi - lo)) >> 16) : lo;
        mark = mark + longint'($urandom_range(0, 6)) - 3;
      end
      default: mark = ($urandom_range(0, 1) != 0) ? lo : hi;
    endcase
    if (mark < 0) mark = 0;
    if (mark > 16383) mark = 16383;
    return DistW'(mark);
  endfunction

  task automatic random_scans(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_scan(pick_dist(), pick_dist(), pick_dist(), pick_dist());
    end
  endtask

  // result side: random stall bursts, and the long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // watchdog on cycles with no item moving
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("testbench: no item moved for %0d cycles", StallLimit);
    $display("testbench: done, errors");
    $finish;
  end

  // stimulus and verdict
  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_addr         = CfgRangeMin;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.dist_left  = '0;
    in_ch.dist_front = '0;
    in_ch.dist_right = '0;
    in_ch.dist_back  = '0;
    idle_on          = 1'b1;
    hold_req         = 1'b0;
    settings         = 1;
    cur_min          = RangeMinRst;
    cur_max          = RangeMaxRst;
    cur_enter        = EnterRst;
    cur_exit         = ExitRst;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // reset registers: each kind but the dead end found, held and released
    send_scan('0, '0, '0, '0);
    send_scan(DistTop, DistTop, DistTop, DistTop);
    send_scan(Far, Far, Far, Far);
    send_scan('0, Far, Far, Far);
    send_scan(Near, Far, Far, Far);
    send_scan(Far, Far, Far, Far);
    send_scan(Far, Far, Near, Far);
    send_scan(Far, Far, Far, Far);
    send_scan(Far, Near, Far, Far);
    send_scan(Far, Far, Far, Far);
    send_scan(Far, Near, Near, Far);
    send_scan(Far, Far, Near, Far);
    send_scan(Far, Near, Near, Far);
    send_scan(Near, Near, Far, Far);
    send_scan(Near, Near, Far, Far);
    send_scan(Far, Far, Far, Near);
    send_scan(DistW'(2500), DistW'(2501), DistW'(525), DistW'(526));

    // random, with the long hold-off and a full pause of the sender
    random_scans(100);
    hold_req = 1'b1;
    random_scans(100);
    drain();
    random_scans(80);

    // widest range, extreme levels
    apply_setting(DistW'(0), DistTop, LevelW'(65536), LevelW'(0), LevelW'(0));
    random_scans(200);

    // empty range, plus a write to an index with no register
    apply_setting(DistW'(1000), DistW'(1000), EnterRst, ExitRst, LevelW'(0));
    write_reg(CfgNoReg, '1);
    send_scan(DistW'(1000), DistW'(999), DistW'(1001), DistW'(1000));
    send_scan(DistTop, '0, DistW'(1000), DistTop);
    send_scan('0, '0, '0, '0);
    random_scans(150);

    // inverted range, no idling on either side
    idle_on = 1'b0;
    apply_setting(DistTop, DistW'(0), LevelW'(20000), LevelW'(10000), LevelW'(0));
    random_scans(120);
    idle_on = 1'b1;

    // levels that can never be exceeded
    apply_setting(DistW'(200), DistW'(3000), '1, '1, LevelW'(0));
    random_scans(120);

    // random ranges and levels
    repeat (5) begin
      apply_setting(DistW'($urandom_range(0, 4000)), DistW'($urandom_range(4001, 10000)),
                    LevelW'($urandom_range(2000, 40000)), LevelW'($urandom_range(0, 30000)),
                    LevelW'(0));
      random_scans(130);
    end

    // last part: dead end, held from here on, no idling
    idle_on = 1'b0;
    apply_setting(DistW'(0), DistW'(2500), EnterRst, ExitRst, '1);
    send_scan(Near, Near, Near, Far);
    random_scans(120);

    drain();
    repeat (30) @(negedge clk);
    $display("summary: %0d scans checked over %0d register settings (empty and inverted ranges)",
             checked, settings);
    $display("summary: junction codes reported %b, dead end held to the end", kinds_seen);
    if (fails == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/cjt_pkg.sv
rtl/cjt_if.sv
rtl/cjt_lane.sv
rtl/cjt_merge.sv
rtl/corridor_junction_tracker.sv
verif/cjt_verdict_check.sv
verif/testbench.sv
